// ===== design/qifenc_pkg.sv =====
package qifenc_pkg;

  localparam int unsigned NumModes = 7;
  localparam int unsigned InDataWidth = 64;
  localparam int unsigned OutDataWidth = 80;
  localparam int unsigned ApbAddrWidth = 1;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [ApbAddrWidth-1:0] AddrHasReadCodeReg = 1'b0;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoMode = 2'd1;
  localparam logic [1:0] StatusBadAddrLen = 2'd2;

  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirRead = 2'd1;
  localparam logic [1:0] DirWrite = 2'd2;

  localparam logic [24:0] FrInstEn = 25'h10;
  localparam logic [24:0] FrAddrEn = 25'h20;
  localparam logic [24:0] FrOptEn = 25'h40;
  localparam logic [24:0] FrDataEn = 25'h80;
  localparam logic [24:0] FrOptL8 = 25'h300;
  localparam logic [24:0] FrAddrL = 25'h400;
  localparam logic [24:0] FrWrite = 25'h2000;
  localparam logic [24:0] FrReadType = 25'h1000000;

  typedef struct packed {
    logic [1:0]  data_dir;
    logic [2:0]  data_width;
    logic        data_present;
    logic [2:0]  dummy_width;
    logic [3:0]  dummy_nbytes;
    logic [31:0] addr_value;
    logic [2:0]  addr_width;
    logic [2:0]  addr_nbytes;
    logic [2:0]  cmd_width;
    logic [7:0]  cmd_opcode;
  } op_t;

  typedef struct packed {
    logic        code_reg_select;
    logic [24:0] frame_word;
    logic [23:0] code_word;
    logic [26:0] addr_word;
    logic        op_supported;
    logic [1:0]  status;
  } frame_t;

  function automatic logic [8:0] mode_lanes(logic [2:0] idx);
    logic [8:0] l;
    begin
      unique case (idx)
        3'd0: l = {3'd1, 3'd1, 3'd1};
        3'd1: l = {3'd1, 3'd1, 3'd2};
        3'd2: l = {3'd1, 3'd1, 3'd4};
        3'd3: l = {3'd1, 3'd2, 3'd2};
        3'd4: l = {3'd1, 3'd4, 3'd4};
        3'd5: l = {3'd2, 3'd2, 3'd2};
        3'd6: l = {3'd4, 3'd4, 3'd4};
        default: l = '0;
      endcase
      return l;
    end
  endfunction

  function automatic logic [3:0] addr_byte_cycles(logic [2:0] aw);
    logic [3:0] c;
    begin
      case (aw)
        3'd1: c = 4'd8;
        3'd2: c = 4'd4;
        3'd3: c = 4'd2;
        3'd4: c = 4'd2;
        3'd5: c = 4'd1;
        3'd6: c = 4'd1;
        3'd7: c = 4'd1;
        default: c = 4'd0;
      endcase
      return c;
    end
  endfunction

  function automatic logic [6:0] dummy_div(logic [6:0] x, logic [2:0] d);
    logic [7:0]  recip;
    logic [14:0] prod;
    logic [6:0]  q;
    logic [9:0]  qd;
    logic [9:0]  r;
    begin
      case (d)
        3'd3: recip = 8'd85;
        3'd5: recip = 8'd51;
        3'd6: recip = 8'd42;
        3'd7: recip = 8'd36;
        default: recip = 8'd0;
      endcase
      prod = {8'd0, x} * {7'd0, recip};
      q = prod[14:8];
      qd = {3'd0, q} * {7'd0, d};
      r = {3'd0, x} - qd;
      if (r >= {7'd0, d}) begin
        q = q + 7'd1;
      end
      case (d)
        3'd1: q = x;
        3'd2: q = {1'b0, x[6:1]};
        3'd4: q = {2'b0, x[6:2]};
        3'd0: q = '0;
        default: ;
      endcase
      return q;
    end
  endfunction

endpackage

// ===== design/qifenc_cfg.sv =====
module qifenc_cfg (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [qifenc_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [qifenc_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [qifenc_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                   pready,
  output logic                                   has_read_code_reg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (paddr == qifenc_pkg::AddrHasReadCodeReg);

  always_ff @(posedge clk) begin
    if (rst) begin
      has_read_code_reg <= 1'b0;
    end else if (wr_en) begin
      has_read_code_reg <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == qifenc_pkg::AddrHasReadCodeReg) begin
      prdata[0] = has_read_code_reg;
    end
  end

endmodule

// ===== design/qifenc_core.sv =====
module qifenc_core (
  input  qifenc_pkg::op_t    op,
  input  logic               has_read_code_reg,
  output qifenc_pkg::frame_t res
);

  logic       found;
  logic [2:0] mode;
  logic [8:0] lanes;
  logic [6:0] dcyc;
  logic [6:0] dcyc_adj;
  logic [3:0] abyte;
  logic       bad_len;
  logic       supported;
  logic [26:0] iar;
  logic [23:0] icr;
  logic [24:0] ifr;

  always_comb begin
    found = 1'b0;
    mode = '0;
    lanes = '0;
    for (int i = qifenc_pkg::NumModes - 1; i >= 0; i--) begin
      lanes = qifenc_pkg::mode_lanes(3'(i));
      if (op.cmd_width == lanes[8:6] &&
          (op.addr_nbytes == 3'd0 || op.addr_width == lanes[5:3]) &&
          (!op.data_present || op.data_width == lanes[2:0])) begin
        found = 1'b1;
        mode = 3'(i);
      end
    end
  end

  always_comb begin
    supported = found && !(op.addr_nbytes == 3'd2 && op.cmd_width != op.addr_width &&
                           op.dummy_nbytes == 4'd0);
    dcyc = '0;
    if (op.dummy_width != 3'd0 && op.dummy_nbytes != 4'd0) begin
      dcyc = qifenc_pkg::dummy_div({op.dummy_nbytes, 3'b000}, op.dummy_width);
    end
    abyte = qifenc_pkg::addr_byte_cycles(op.addr_width);
    dcyc_adj = dcyc;
    iar = '0;
    icr = {16'd0, op.cmd_opcode};
    ifr = qifenc_pkg::FrInstEn | {22'd0, mode};
    bad_len = 1'b0;
    if (op.addr_width != 3'd0) begin
      case (op.addr_nbytes)
        3'd0: ;
        3'd1: begin
          ifr = ifr | qifenc_pkg::FrOptEn | qifenc_pkg::FrOptL8;
          icr[23:16] = op.addr_value[7:0];
        end
        3'd2: begin
          if (dcyc < {3'd0, abyte}) begin
            ifr = (ifr & ~qifenc_pkg::FrInstEn) | qifenc_pkg::FrAddrEn;
            iar = {3'd0, op.cmd_opcode, op.addr_value[15:0]};
          end else begin
            ifr = ifr | qifenc_pkg::FrAddrEn;
            iar = {3'd0, op.addr_value[15:0], 8'd0};
            dcyc_adj = dcyc - {3'd0, abyte};
          end
        end
        3'd3: begin
          ifr = ifr | qifenc_pkg::FrAddrEn;
          iar = {3'd0, op.addr_value[23:0]};
        end
        3'd4: begin
          ifr = ifr | qifenc_pkg::FrAddrEn | qifenc_pkg::FrAddrL;
          iar = op.addr_value[26:0];
        end
        default: bad_len = 1'b1;
      endcase
    end
    ifr[20:16] = dcyc_adj[4:0];
    if (op.data_present) begin
      ifr = ifr | qifenc_pkg::FrDataEn;
    end
    res.code_reg_select = 1'b0;
    if (has_read_code_reg) begin
      if (op.addr_nbytes == 3'd0 && op.data_dir == qifenc_pkg::DirRead) begin
        ifr = ifr | qifenc_pkg::FrReadType;
      end
      res.code_reg_select = (op.data_dir == qifenc_pkg::DirRead);
    end else if (op.data_dir == qifenc_pkg::DirWrite) begin
      ifr = ifr | qifenc_pkg::FrWrite;
    end

    res.op_supported = supported;
    res.status = qifenc_pkg::StatusOk;
    res.addr_word = iar;
    res.code_word = icr;
    res.frame_word = ifr;
    if (!found || bad_len) begin
      res.status = found ? qifenc_pkg::StatusBadAddrLen : qifenc_pkg::StatusNoMode;
      res.addr_word = '0;
      res.code_word = '0;
      res.frame_word = '0;
      res.code_reg_select = 1'b0;
    end
  end

endmodule

// ===== design/qspi_instruction_frame_encoder_unit.sv =====
// Serial-flash instruction frame encoder.
// One operation enters per beat on the s_axis channel; s_tdata carries the
// opcode, lane widths, address length and value, dummy bytes, data presence
// and data direction. The m_axis channel returns one beat per operation with
// the status, support verdict, address word, code word, frame word and code
// register select.
// The APB port holds one register, has_read_code_reg, at byte address 0.
// Each beat passes through the input register and then the result register,
// with the encode logic in between. Throughput is one operation per cycle
// while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the
// input register fills; s_tready drops only when both are occupied, so no
// beat is lost or repeated.
// Reset empties both stages and clears has_read_code_reg to 0.
module qspi_instruction_frame_encoder_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // cmd_opcode, cmd_width, addr_nbytes, addr_width, addr_value,
  // dummy_nbytes, dummy_width, data_present, data_width, data_dir
  input  logic [qifenc_pkg::InDataWidth-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // status, op_supported, addr_word, code_word, frame_word, code_reg_select
  output logic [qifenc_pkg::OutDataWidth-1:0]      m_tdata,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [qifenc_pkg::ApbAddrWidth-1:0]      paddr,
  input  logic [qifenc_pkg::ApbDataWidth-1:0]      pwdata,
  output logic [qifenc_pkg::ApbDataWidth-1:0]      prdata,
  output logic                                     pready
);

  logic               has_read_code_reg;
  logic               in_valid;
  qifenc_pkg::op_t    in_op;
  qifenc_pkg::frame_t enc_res;
  qifenc_pkg::frame_t out_res;
  logic               out_free;
  logic               in_free;

  qifenc_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .has_read_code_reg (has_read_code_reg)
  );

  qifenc_core u_core (
    .op                (in_op),
    .has_read_code_reg (has_read_code_reg),
    .res               (enc_res)
  );

  assign out_free = !m_tvalid || m_tready;
  assign in_free = !in_valid || out_free;
  assign s_tready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_tvalid) begin
      in_op <= qifenc_pkg::op_t'(s_tdata[61:0]);
    end
    if (out_free && in_valid) begin
      out_res <= enc_res;
    end
  end

  assign m_tdata = out_res;

endmodule

// ===== verif/qifenc_frame_checker.sv =====
module qifenc_frame_checker
  import qifenc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [InDataWidth-1:0]  s_tdata,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [OutDataWidth-1:0] m_tdata,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output int                      pending,
  output int                      errors,
  output int                      checked,
  output int                      no_mode_seen,
  output int                      bad_len_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Lane widths of the seven width modes, mode 0 in the lowest slot.
  localparam logic [6:0][2:0] CmdLanes  = {3'd4, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
  localparam logic [6:0][2:0] AddrLanes = {3'd4, 3'd2, 3'd4, 3'd2, 3'd1, 3'd1, 3'd1};
  localparam logic [6:0][2:0] DataLanes = {3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd2, 3'd1};
  localparam logic [31:0] DummyMask = 32'h1f_0000;

  frame_t frame_q[$];
  logic   read_reg_variant;
  int     err_n, chk_n, nomode_n, badlen_n;

  function automatic frame_t encode_frame(op_t op, logic rd_variant);
    frame_t      r;
    int unsigned mode;
    int unsigned dcyc;
    int unsigned abyte;
    logic [31:0] ifr;
    logic [31:0] icr;
    logic [31:0] iar;
    logic [1:0]  st;
    r = '0;
    mode = 7;
    for (int i = 6; i >= 0; i--) begin
      if (op.cmd_width == CmdLanes[i] &&
          (op.addr_nbytes == 0 || op.addr_width == AddrLanes[i]) &&
          (!op.data_present || op.data_width == DataLanes[i]))
        mode = i;
    end
    r.op_supported = (mode < 7) &&
                     !(op.addr_nbytes == 2 && op.cmd_width != op.addr_width &&
                       op.dummy_nbytes == 0);
    if (mode >= 7) begin
      r.status = StatusNoMode;
      return r;
    end
    icr = {24'd0, op.cmd_opcode};
    ifr = {7'd0, FrInstEn} | mode;
    iar = '0;
    st = StatusOk;
    dcyc = 0;
    if (op.dummy_width != 0 && op.dummy_nbytes != 0)
      dcyc = (32'(op.dummy_nbytes) * 8) / 32'(op.dummy_width);
    if (op.addr_width != 0) begin
      abyte = 8 / 32'(op.addr_width);
      case (op.addr_nbytes)
        3'd0: ;
        3'd1: begin
          ifr = ifr | FrOptEn | FrOptL8;
          icr = icr | ({24'd0, op.addr_value[7:0]} << 16);
        end
        3'd2: begin
          if (dcyc < abyte) begin
            ifr = (ifr & ~{7'd0, FrInstEn}) | FrAddrEn;
            iar = ({24'd0, op.cmd_opcode} << 16) | (op.addr_value & 32'hffff);
          end else begin
            ifr = ifr | FrAddrEn;
            iar = (op.addr_value << 8) & 32'hff_ffff;
            dcyc = dcyc - abyte;
          end
        end
        3'd3: begin
          ifr = ifr | FrAddrEn;
          iar = op.addr_value & 32'hff_ffff;
        end
        3'd4: begin
          ifr = ifr | FrAddrEn | FrAddrL;
          iar = op.addr_value & 32'h7ff_ffff;
        end
        default: st = StatusBadAddrLen;
      endcase
    end
    if (st != StatusOk) begin
      r.status = st;
      return r;
    end
    ifr = ifr | ((dcyc << 16) & DummyMask);
    if (op.data_present)
      ifr = ifr | FrDataEn;
    if (rd_variant) begin
      if (op.addr_nbytes == 0 && op.data_dir == DirRead)
        ifr = ifr | FrReadType;
      r.code_reg_select = (op.data_dir == DirRead);
    end else if (op.data_dir == DirWrite) begin
      ifr = ifr | FrWrite;
    end
    r.status = StatusOk;
    r.addr_word = iar[26:0];
    r.code_word = icr[23:0];
    r.frame_word = ifr[24:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_n++;
    end
  endtask

  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (rst) begin
      frame_q.delete();
      read_reg_variant <= 1'b0;
      err_n = 0;
      chk_n = 0;
      nomode_n = 0;
      badlen_n = 0;
    end else begin
      if (s_tvalid && s_tready)
        frame_q.push_back(encode_frame(op_t'(s_tdata[$bits(op_t)-1:0]), read_reg_variant));
      if (m_tvalid && m_tready) begin
        got = frame_t'(m_tdata);
        if (frame_q.size() == 0) begin
          $error("Result beat arrived with no operation outstanding: 0x%0h", m_tdata);
          err_n++;
        end else begin
          want = frame_q.pop_front();
          chk_n++;
          if (want.status == StatusNoMode) nomode_n++;
          if (want.status == StatusBadAddrLen) badlen_n++;
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("op_supported", 32'(want.op_supported), 32'(got.op_supported));
          compare_field("addr_word", 32'(want.addr_word), 32'(got.addr_word));
          compare_field("code_word", 32'(want.code_word), 32'(got.code_word));
          compare_field("frame_word", 32'(want.frame_word), 32'(got.frame_word));
          compare_field("code_reg_select", 32'(want.code_reg_select),
                        32'(got.code_reg_select));
        end
      end
      if (psel && penable && pwrite && pready && paddr == AddrHasReadCodeReg)
        read_reg_variant <= pwdata[0];
    end
    pending <= frame_q.size();
    errors <= err_n;
    checked <= chk_n;
    no_mode_seen <= nomode_n;
    bad_len_seen <= badlen_n;
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qifenc_pkg::*;

  localparam logic [1:0] DirOther = 2'd3;
  localparam int IdleLimit = 5000;
  localparam int LongHold = 400;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  int pending, errors, checked, no_mode_seen, bad_len_seen;
  int ops_sent;
  int idle_cycles;
  bit tx_steady, rx_steady, hold_req;

  qspi_instruction_frame_encoder_unit dut (.*);

  qifenc_frame_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0)
      return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [2:0] pick_lanes();
    return 3'(1 << $urandom_range(0, 2));
  endfunction

  function automatic op_t mk_op(logic [7:0] opc, logic [2:0] cw, logic [2:0] anb,
                                logic [2:0] aw, logic [31:0] aval, logic [3:0] dnb,
                                logic [2:0] dw, logic dp, logic [2:0] daw, logic [1:0] dir);
    op_t op;
    op.cmd_opcode = opc;
    op.cmd_width = cw;
    op.addr_nbytes = anb;
    op.addr_width = aw;
    op.addr_value = aval;
    op.dummy_nbytes = dnb;
    op.dummy_width = dw;
    op.data_present = dp;
    op.data_width = daw;
    op.data_dir = dir;
    return op;
  endfunction

  // Mostly operations whose lane widths fit one of the width modes, with the
  // rest as unconstrained noise.
  function automatic op_t random_op();
    op_t op;
    int  k;
    op.cmd_opcode = 8'($urandom);
    k = $urandom_range(0, 9);
    op.addr_value = (k == 0) ? 32'd0 : (k == 1) ? '1 : $urandom;
    k = $urandom_range(0, 99);
    op.addr_nbytes = (k < 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    op.dummy_nbytes = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom);
    op.dummy_width = ($urandom_range(0, 3) == 0) ? 3'($urandom) :
                     ($urandom_range(0, 4) == 0) ? 3'd0 : pick_lanes();
    op.data_present = 1'($urandom);
    op.data_dir = ($urandom_range(0, 7) == 0) ? DirOther : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 12) begin
      op.cmd_width = 3'($urandom);
      op.addr_width = 3'($urandom);
      op.data_width = 3'($urandom);
    end else begin
      k = $urandom_range(0, 4);
      op.cmd_width = (k < 3) ? 3'd1 : (k == 3) ? 3'd2 : 3'd4;
      if (op.cmd_width == 3'd1) begin
        op.addr_width = pick_lanes();
        op.data_width = (op.addr_width == 3'd1) ? pick_lanes() : op.addr_width;
      end else begin
        op.addr_width = op.cmd_width;
        op.data_width = op.cmd_width;
      end
      if (op.addr_nbytes == 0 && $urandom_range(0, 3) == 0)
        op.addr_width = 3'($urandom);
      if (!op.data_present && $urandom_range(0, 3) == 0)
        op.data_width = 3'($urandom);
    end
    return op;
  endfunction

  task automatic send_op(op_t op);
    int gap;
    s_tdata <= InDataWidth'(op);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ops_sent++;
    gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [ApbAddrWidth-1:0] addr, logic [ApbDataWidth-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no beat moved for %0d cycles.", IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ops_sent = 0;
    idle_cycles = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_op(mk_op(8'h00, 3'd0, 3'd0, 3'd0, 32'd0, 4'd0, 3'd0, 1'b0, 3'd0, DirNone));
    send_op(mk_op(8'hFF, 3'd1, 3'd0, 3'd0, '1, 4'd0, 3'd0, 1'b0, 3'd0, DirNone));
    send_op(mk_op(8'h03, 3'd1, 3'd1, 3'd1, '1, 4'd0, 3'd0, 1'b1, 3'd1, DirRead));
    send_op(mk_op(8'hA5, 3'd1, 3'd2, 3'd1, '1, 4'd0, 3'd0, 1'b0, 3'd0, DirNone));
    send_op(mk_op(8'h5A, 3'd1, 3'd2, 3'd1, 32'h1234_5678, 4'd1, 3'd1, 1'b1, 3'd1, DirRead));
    send_op(mk_op(8'h3B, 3'd1, 3'd2, 3'd2, '1, 4'd0, 3'd0, 1'b1, 3'd2, DirRead));
    send_op(mk_op(8'h3C, 3'd1, 3'd2, 3'd2, 32'hDEAD_BEEF, 4'd2, 3'd2, 1'b1, 3'd2, DirRead));
    send_op(mk_op(8'hEB, 3'd4, 3'd3, 3'd4, '1, 4'd3, 3'd4, 1'b1, 3'd4, DirRead));
    send_op(mk_op(8'h6C, 3'd1, 3'd4, 3'd4, '1, 4'd4, 3'd4, 1'b1, 3'd4, DirRead));
    send_op(mk_op(8'h0C, 3'd1, 3'd4, 3'd1, '1, 4'd0, 3'd0, 1'b0, 3'd0, DirWrite));
    send_op(mk_op(8'h12, 3'd1, 3'd5, 3'd1, '1, 4'd1, 3'd1, 1'b0, 3'd0, DirRead));
    send_op(mk_op(8'h13, 3'd4, 3'd7, 3'd4, '1, 4'd15, 3'd7, 1'b1, 3'd4, DirWrite));
    send_op(mk_op(8'h14, 3'd1, 3'd6, 3'd0, '1, 4'd0, 3'd0, 1'b0, 3'd0, DirNone));
    send_op(mk_op(8'h0B, 3'd1, 3'd0, 3'd0, 32'd0, 4'd15, 3'd1, 1'b1, 3'd1, DirRead));
    send_op(mk_op(8'h0B, 3'd1, 3'd3, 3'd1, '1, 4'd15, 3'd3, 1'b1, 3'd1, DirRead));
    send_op(mk_op(8'h0B, 3'd2, 3'd3, 3'd2, '1, 4'd13, 3'd7, 1'b1, 3'd2, DirRead));
    send_op(mk_op(8'h0B, 3'd1, 3'd3, 3'd1, '1, 4'd15, 3'd0, 1'b0, 3'd0, DirNone));
    send_op(mk_op(8'h02, 3'd2, 3'd3, 3'd2, '1, 4'd0, 3'd0, 1'b1, 3'd2, DirWrite));
    send_op(mk_op(8'h77, 3'd1, 3'd3, 3'd1, '1, 4'd1, 3'd5, 1'b1, 3'd4, DirOther));
    send_op(mk_op(8'h01, 3'd1, 3'd0, 3'd7, 32'd0, 4'd0, 3'd6, 1'b1, 3'd3, DirRead));
    send_op(mk_op(8'h9F, 3'd7, 3'd0, 3'd0, 32'd0, 4'd0, 3'd0, 1'b0, 3'd0, DirRead));
    send_op(mk_op(8'h9F, 3'd1, 3'd0, 3'd0, 32'd0, 4'd0, 3'd0, 1'b1, 3'd2, DirRead));
    send_op(mk_op(8'h9F, 3'd1, 3'd2, 3'd4, '1, 4'd0, 3'd0, 1'b0, 3'd0, DirNone));
    send_op(mk_op(8'hFF, 3'd2, 3'd2, 3'd2, '1, 4'd0, 3'd0, 1'b0, 3'd0, DirNone));

    drain_results();
    apb_write(AddrHasReadCodeReg, 32'h1);
    for (int i = 0; i < 550; i++) begin
      if (i == 200) hold_req = 1'b1;
      send_op(random_op());
    end

    drain_results();
    apb_write(AddrHasReadCodeReg, {31'($urandom), 1'b0});
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int i = 0; i < 600; i++) begin
      if (i == 150) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      send_op(random_op());
    end

    drain_results();
    apb_write(AddrHasReadCodeReg, {31'($urandom), 1'b1});
    for (int i = 0; i < 600; i++) begin
      if (i == 300) drain_results();
      if (i == 450) hold_req = 1'b1;
      send_op(random_op());
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d operations with the read code register variant both off and on.",
             ops_sent);
    $display("Checked %0d frames: %0d without a width mode, %0d with a bad address length.",
             checked, no_mode_seen, bad_len_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
